@@ rtl/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with reserve/commit access.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    // Field widths of the channels
    localparam int OP_W      = 3;
    localparam int DATA_W    = 8;
    localparam int AMT_W     = 11;
    localparam int CNT_W     = 11;
    localparam int IDX_OUT_W = 10;
    localparam int RS_W      = 11;

    // Default ring storage depth
    localparam int DEPTH_DEF = 1024;

    // Ring size after reset
    localparam logic [RS_W-1:0] RING_SIZE_RST = 11'd1024;

    // Smallest legal ring size
    localparam int RING_SIZE_MIN = 2;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_RSV_WR    = 3'd2,
        OP_WRITE_AT  = 3'd3,
        OP_COMMIT_WR = 3'd4,
        OP_RSV_RD    = 3'd5,
        OP_PEEK_AT   = 3'd6,
        OP_RELEASE   = 3'd7
    } op_t;

    // Sticky error codes
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } err_t;

    // Result of one operation, held until the response beat is taken
    typedef struct packed {
        logic                 rd_sel;   // read_data comes from the RAM
        logic [CNT_W-1:0]     grant;
        logic [IDX_OUT_W-1:0] start;
        logic [IDX_OUT_W-1:0] occ;
        err_t                 err;
    } rslt_t;

endpackage

`default_nettype wire

@@ rtl/brf_if.sv @@
// ----------------------------------------------------------------------------
// brf_if
// Valid/ready channels of the byte ring FIFO: request, response and config.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one operation per beat
interface brf_req_if;
    logic                           valid;
    logic                           ready;
    logic [brf_pkg::OP_W-1:0]       op;
    logic [brf_pkg::DATA_W-1:0]     write_data;
    logic [brf_pkg::AMT_W-1:0]      amount;

    modport source (output valid, output op, output write_data, output amount,
                    input ready);
    modport sink   (input valid, input op, input write_data, input amount,
                    output ready);
endinterface

// Response channel: one result per request beat
interface brf_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [brf_pkg::DATA_W-1:0]     read_data;
    logic [brf_pkg::CNT_W-1:0]      grant_count;
    logic [brf_pkg::IDX_OUT_W-1:0]  start_index;
    logic [brf_pkg::IDX_OUT_W-1:0]  occupancy;
    logic [1:0]                     error_code;

    modport source (output valid, output read_data, output grant_count,
                    output start_index, output occupancy, output error_code,
                    input ready);
    modport sink   (input valid, input read_data, input grant_count,
                    input start_index, input occupancy, input error_code,
                    output ready);
endinterface

// Config channel: ring_size register write
interface brf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [brf_pkg::RS_W-1:0]       ring_size;

    modport source (output valid, output ring_size, input ready);
    modport sink   (input valid, input ring_size, output ready);
endinterface

`default_nettype wire

@@ rtl/brf_ram.sv @@
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/brf_ctrl.sv @@
// ----------------------------------------------------------------------------
// brf_ctrl
// Index and error state, operation decode, RAM access issue and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ctrl #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    brf_req_if.sink                       req,
    brf_cfg_if.sink                       cfg,
    input  wire logic                     rsp_ready,
    output logic                          rsp_valid,
    output brf_pkg::rslt_t                rslt,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic                          mem_re,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SZ_W  = IDX_W + 1;
    localparam int CW    = ((SZ_W > brf_pkg::AMT_W) ? SZ_W : brf_pkg::AMT_W) + 1;

    logic [brf_pkg::RS_W-1:0] ring_size_reg;
    logic [IDX_W-1:0]         wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    brf_pkg::err_t            err_reg, err_next;
    logic                     valid_reg;
    brf_pkg::rslt_t           rslt_reg, rslt_next;

    logic                     accept;
    logic [CW-1:0]            rs, sc, w, r, am, occ, freesp, occ_after;
    logic [CW-1:0]            n_wr, n_rd, w_new, r_new, grant, start;
    logic                     rd_sel;
    brf_pkg::op_t             op;

    // Add within the ring; the wrap is right only while both terms stay below the ring size
    function automatic logic [CW-1:0] ring_add(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b,
                                               input logic [CW-1:0] size);
        logic [CW-1:0] s;
        s = a + b;
        return (s >= size) ? (s - size) : s;
    endfunction

    assign req.ready = !valid_reg || rsp_ready;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign op        = brf_pkg::op_t'(req.op);

    // Effective ring size, clamped to 2..DEPTH
    always_comb
    begin
        rs = CW'(ring_size_reg);
        if (rs < CW'(brf_pkg::RING_SIZE_MIN))
        begin
            sc = CW'(brf_pkg::RING_SIZE_MIN);
        end
        else if (rs > CW'(DEPTH))
        begin
            sc = CW'(DEPTH);
        end
        else
        begin
            sc = rs;
        end
    end

    // Occupancy and free space before the op
    assign w      = CW'(wr_idx_reg);
    assign r      = CW'(rd_idx_reg);
    assign am     = CW'(req.amount);
    assign occ    = (w >= r) ? (w - r) : (w + sc - r);
    assign freesp = sc - CW'(1) - occ;

    // Operation decode
    always_comb
    begin
        n_wr      = '0;
        n_rd      = '0;
        grant     = '0;
        rd_sel    = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = wr_idx_reg;
        mem_raddr = rd_idx_reg;
        err_next  = err_reg;
        start     = r;
        case (op)
            brf_pkg::OP_PUSH:
            begin
                start = w;
                if (freesp == '0)
                begin
                    err_next = brf_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    mem_we = accept;
                    n_wr   = CW'(1);
                end
            end
            brf_pkg::OP_POP:
            begin
                if (occ == '0)
                begin
                    err_next = brf_pkg::ERR_UNDERFLOW;
                end
                else
                begin
                    mem_re = accept;
                    rd_sel = 1'b1;
                    n_rd   = CW'(1);
                end
            end
            brf_pkg::OP_RSV_WR:
            begin
                start = w;
                grant = (am < freesp) ? am : freesp;
                if (grant == '0)
                begin
                    err_next = brf_pkg::ERR_OVERFLOW;
                end
            end
            brf_pkg::OP_WRITE_AT:
            begin
                start     = w;
                mem_waddr = IDX_W'(ring_add(w, am, sc));
                if (am < freesp)
                begin
                    mem_we = accept;
                end
                else
                begin
                    err_next = brf_pkg::ERR_OVERFLOW;
                end
            end
            brf_pkg::OP_COMMIT_WR:
            begin
                start = w;
                if (am > freesp)
                begin
                    n_wr     = freesp;
                    err_next = brf_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    n_wr = am;
                end
                grant = n_wr;
            end
            brf_pkg::OP_RSV_RD:
            begin
                if (occ == '0)
                begin
                    err_next = brf_pkg::ERR_UNDERFLOW;
                end
                else
                begin
                    grant = (am < occ) ? am : occ;
                end
            end
            brf_pkg::OP_PEEK_AT:
            begin
                mem_raddr = IDX_W'(ring_add(r, am, sc));
                if (am < occ)
                begin
                    mem_re = accept;
                    rd_sel = 1'b1;
                end
                else
                begin
                    err_next = brf_pkg::ERR_UNDERFLOW;
                end
            end
            brf_pkg::OP_RELEASE:
            begin
                if (am > occ)
                begin
                    n_rd     = occ;
                    err_next = brf_pkg::ERR_UNDERFLOW;
                end
                else
                begin
                    n_rd = am;
                end
                grant = n_rd;
            end
            default:
            begin
                grant = '0;
            end
        endcase
    end

    // Index advance and occupancy after the op
    assign w_new       = ring_add(w, n_wr, sc);
    assign r_new       = ring_add(r, n_rd, sc);
    assign occ_after   = occ + n_wr - n_rd;
    assign wr_idx_next = IDX_W'(w_new);
    assign rd_idx_next = IDX_W'(r_new);

    // Result fields
    always_comb
    begin
        rslt_next.rd_sel = rd_sel;
        rslt_next.grant  = grant[brf_pkg::CNT_W-1:0];
        rslt_next.start  = start[brf_pkg::IDX_OUT_W-1:0];
        rslt_next.occ    = occ_after[brf_pkg::IDX_OUT_W-1:0];
        rslt_next.err    = err_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= brf_pkg::RING_SIZE_RST;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            err_reg       <= brf_pkg::ERR_NONE;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                // New ring size empties the FIFO, error is kept
                ring_size_reg <= cfg.ring_size;
                wr_idx_reg    <= '0;
                rd_idx_reg    <= '0;
            end
            else if (accept)
            begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
                err_reg    <= err_next;
            end
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rslt_reg <= rslt_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rslt      = rslt_reg;

endmodule

`default_nettype wire

@@ rtl/byte_ring_fifo_reserve_commit.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_reserve_commit
// Byte ring FIFO with push/pop and reserve/commit block access.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per beat (op, write_data, amount); rsp returns
//   one result beat for each request beat, in order. cfg writes ring_size,
//   which also empties the FIFO; write it only while the block is idle.
//   Each request is decoded and its one RAM access (write or read) issued at
//   the accepting edge; the result beat is valid on the following cycle, the
//   byte for pop or peek coming straight from the RAM's registered read port.
//   Throughput is 1 beat per cycle while rsp does not stall: the single byte
//   RAM is touched at most once per operation and the index update is one
//   add with one wrap compare.
//   When rsp stalls, the pending result (and the RAM read data) hold, and
//   req.ready drops until the result beat is taken.
//   Reset clears both indices and the sticky error and sets ring_size to
//   1024; the byte storage is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_reserve_commit #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    brf_req_if.sink    req,
    brf_rsp_if.source  rsp,
    brf_cfg_if.sink    cfg
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                        mem_we;
    logic                        mem_re;
    logic [IDX_W-1:0]            mem_waddr;
    logic [IDX_W-1:0]            mem_raddr;
    logic [brf_pkg::DATA_W-1:0]  mem_rdata;
    brf_pkg::rslt_t              rslt;

    // Control and index state
    brf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rslt      (rslt),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    // Byte storage
    brf_ram #(
        .WIDTH (brf_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.write_data),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Response beat
    assign rsp.read_data   = rslt.rd_sel ? mem_rdata : '0;
    assign rsp.grant_count = rslt.grant;
    assign rsp.start_index = rslt.start;
    assign rsp.occupancy   = rslt.occ;
    assign rsp.error_code  = rslt.err;

endmodule

`default_nettype wire
